// ----- rtl/cbsp_pkg.sv -----
// Package for the sign request parser: payload types, parse state, codes and constants.
package cbsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       msg_end;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  item_index;
        logic [2:0]  byte_role;
        logic [15:0] decoded_value;
        logic        value_valid;
        logic [1:0]  status;
        logic        msg_done;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_ARRAY   = 3'd0,
        PH_HEAD    = 3'd1,
        PH_LEN1    = 3'd2,
        PH_LENHI   = 3'd3,
        PH_LENLO   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_TRAIL   = 3'd6,
        PH_ERR     = 3'd7
    } t_phase;

    typedef struct packed {
        t_phase      parse_phase;
        logic [3:0]  item_number;
        logic [15:0] length_accum;
        logic [15:0] payload_left;
        logic        rejected;
    } t_parse_state;

    localparam logic [2:0] ROLE_ARRAY   = 3'd0;
    localparam logic [2:0] ROLE_HEAD    = 3'd1;
    localparam logic [2:0] ROLE_LENGTH  = 3'd2;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
    localparam logic [2:0] ROLE_TRAIL   = 3'd4;
    localparam logic [2:0] ROLE_ERROR   = 3'd5;

    localparam logic [1:0] ST_PARSING  = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic [2:0] MAJOR_UINT  = 3'd0;
    localparam logic [2:0] MAJOR_BYTES = 3'd2;
    localparam logic [2:0] MAJOR_TEXT  = 3'd3;

    localparam logic [7:0] ARRAY7_HEAD = 8'h87;
    localparam logic [4:0] AI_MASK     = 5'h1F;
    localparam logic [4:0] AI_ONE_BYTE = 5'd24;
    localparam logic [4:0] AI_TWO_BYTE = 5'd25;
    localparam logic [7:0] CBOR_FALSE  = 8'hF4;
    localparam logic [7:0] CBOR_TRUE   = 8'hF5;

    localparam logic [3:0] ITEM_FIRST = 4'd1;
    localparam logic [3:0] ITEM_UINT  = 4'd2;
    localparam logic [3:0] ITEM_TEXT1 = 4'd5;
    localparam logic [3:0] ITEM_BOOL  = 4'd6;
    localparam logic [3:0] ITEM_LAST  = 4'd7;
    localparam logic [3:0] ITEM_AFTER = 4'd8;

    localparam t_parse_state STATE_RESET = '{
        parse_phase:  PH_ARRAY,
        item_number:  4'd0,
        length_accum: 16'd0,
        payload_left: 16'd0,
        rejected:     1'b0
    };

endpackage

// ----- rtl/cbsp_step.sv -----
// Combinational per-byte parse step: next parse state and the result item for one byte.
module cbsp_step (
    input  cbsp_pkg::t_parse_state i_state,
    input  cbsp_pkg::t_in_item     i_in,
    output cbsp_pkg::t_parse_state o_state,
    output cbsp_pkg::t_out_item    o_out
);

    logic [7:0]  b;
    logic [4:0]  ai;
    logic [2:0]  major;
    logic        bad;
    logic        known;
    logic [15:0] known_val;
    logic        finish;
    logic [3:0]  item_inc;
    logic [15:0] left_dec;
    cbsp_pkg::t_parse_state s;

    assign b        = i_in.data_byte;
    assign ai       = b[4:0] & cbsp_pkg::AI_MASK;
    assign item_inc = i_state.item_number + 4'd1;
    assign left_dec = (i_state.payload_left != 16'd0) ? (i_state.payload_left - 16'd1)
                                                       : 16'd0;

    always_comb begin
        if (i_state.item_number == cbsp_pkg::ITEM_UINT) begin
            major = cbsp_pkg::MAJOR_UINT;
        end else if (i_state.item_number == cbsp_pkg::ITEM_TEXT1 ||
                     i_state.item_number == cbsp_pkg::ITEM_LAST) begin
            major = cbsp_pkg::MAJOR_TEXT;
        end else begin
            major = cbsp_pkg::MAJOR_BYTES;
        end
    end

    always_comb begin
        s         = i_state;
        bad       = 1'b0;
        known     = 1'b0;
        known_val = 16'd0;
        finish    = 1'b0;
        o_out     = '0;
        o_out.item_index = i_state.item_number;
        o_out.msg_done   = i_in.msg_end;

        case (i_state.parse_phase)
            cbsp_pkg::PH_ARRAY: begin
                o_out.item_index = 4'd0;
                o_out.byte_role  = cbsp_pkg::ROLE_ARRAY;
                if (b == cbsp_pkg::ARRAY7_HEAD) begin
                    s.item_number = cbsp_pkg::ITEM_FIRST;
                    s.parse_phase = cbsp_pkg::PH_HEAD;
                end else begin
                    bad = 1'b1;
                end
            end
            cbsp_pkg::PH_HEAD: begin
                o_out.byte_role = cbsp_pkg::ROLE_HEAD;
                if (i_state.item_number < cbsp_pkg::ITEM_FIRST ||
                    i_state.item_number > cbsp_pkg::ITEM_LAST) begin
                    bad = 1'b1;
                end else if (i_state.item_number == cbsp_pkg::ITEM_BOOL) begin
                    if (b == cbsp_pkg::CBOR_FALSE || b == cbsp_pkg::CBOR_TRUE) begin
                        o_out.decoded_value = {15'd0, b == cbsp_pkg::CBOR_TRUE};
                        o_out.value_valid   = 1'b1;
                        finish              = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end else if (b[7:5] != major) begin
                    bad = 1'b1;
                end else if (ai < cbsp_pkg::AI_ONE_BYTE) begin
                    known     = 1'b1;
                    known_val = {11'd0, ai};
                end else if (ai == cbsp_pkg::AI_ONE_BYTE) begin
                    s.parse_phase = cbsp_pkg::PH_LEN1;
                end else if (ai == cbsp_pkg::AI_TWO_BYTE) begin
                    s.parse_phase = cbsp_pkg::PH_LENHI;
                end else begin
                    bad = 1'b1;
                end
            end
            cbsp_pkg::PH_LEN1: begin
                o_out.byte_role = cbsp_pkg::ROLE_LENGTH;
                known           = 1'b1;
                known_val       = {8'd0, b};
            end
            cbsp_pkg::PH_LENHI: begin
                o_out.byte_role = cbsp_pkg::ROLE_LENGTH;
                s.length_accum  = {b, 8'd0};
                s.parse_phase   = cbsp_pkg::PH_LENLO;
            end
            cbsp_pkg::PH_LENLO: begin
                o_out.byte_role = cbsp_pkg::ROLE_LENGTH;
                known           = 1'b1;
                known_val       = i_state.length_accum | {8'd0, b};
            end
            cbsp_pkg::PH_PAYLOAD: begin
                o_out.byte_role = cbsp_pkg::ROLE_PAYLOAD;
                s.payload_left  = left_dec;
                finish          = (left_dec == 16'd0);
            end
            cbsp_pkg::PH_TRAIL: begin
                o_out.item_index = cbsp_pkg::ITEM_AFTER;
                o_out.byte_role  = cbsp_pkg::ROLE_TRAIL;
            end
            default: begin
                o_out.byte_role = cbsp_pkg::ROLE_ERROR;
                o_out.status    = cbsp_pkg::ST_REJECTED;
            end
        endcase

        // A completed head value either closes the item (the uint, or an empty string)
        // or opens the string payload.
        if (known) begin
            o_out.decoded_value = known_val;
            o_out.value_valid   = 1'b1;
            if (i_state.item_number == cbsp_pkg::ITEM_UINT || known_val == 16'd0) begin
                finish = 1'b1;
            end else begin
                s.payload_left = known_val;
                s.parse_phase  = cbsp_pkg::PH_PAYLOAD;
            end
        end

        if (finish) begin
            s.item_number = item_inc;
            s.parse_phase = (item_inc >= cbsp_pkg::ITEM_AFTER) ? cbsp_pkg::PH_TRAIL
                                                                : cbsp_pkg::PH_HEAD;
        end

        if (bad) begin
            s.parse_phase = cbsp_pkg::PH_ERR;
            s.rejected    = 1'b1;
            o_out.status  = cbsp_pkg::ST_REJECTED;
        end

        if (i_in.msg_end) begin
            o_out.status = (s.parse_phase == cbsp_pkg::PH_TRAIL && !s.rejected)
                           ? cbsp_pkg::ST_ACCEPTED : cbsp_pkg::ST_REJECTED;
            s = cbsp_pkg::STATE_RESET;
        end

        o_state = s;
    end

endmodule

// ----- rtl/cbor_sign_request_parser.sv -----
// Top level of the sign request parser: input register, parse state and result register.
//
// The block checks a message of the fixed shape array(7) = [bytes, uint, bytes, bytes,
// text, bool, text] as it streams in, one byte per input item, the last byte of a
// message flagged by msg_end. For every input item it delivers exactly one result item:
// the item number the byte belongs to, its role, any uint, bool or length completed on
// it, a status and a copy of the end flag.
//
// Both channels use valid and ready. An accepted byte lands in an input register; the
// parse step reads it there together with the parse state, updates the state and loads
// the result register once that register is free. One byte can be accepted in every
// cycle while the receiver keeps taking results: the only loop is the per-byte parse
// state update, a single short step.
//
// When the receiver stalls, the result register holds its item and the input register
// holds the next byte; once both are full, ready drops until the receiver takes a
// result. No item is lost or repeated.
//
// Reset empties both registers and returns the parser to expect an array head. After
// each byte that carries msg_end the parser returns to that same state on its own.
module cbor_sign_request_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cbsp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cbsp_pkg::t_out_item o_out_data
);

    logic                   r_in_valid;
    cbsp_pkg::t_in_item     r_in_data;
    logic                   r_out_valid;
    cbsp_pkg::t_out_item    r_out_data;
    cbsp_pkg::t_parse_state r_state;
    cbsp_pkg::t_parse_state n_state;
    cbsp_pkg::t_out_item    n_out_data;

    logic out_free;
    logic advance;

    // The result register can take a new item when it is empty or being emptied.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;

    cbsp_step u_step (
        .i_state (r_state),
        .i_in    (r_in_data),
        .o_state (n_state),
        .o_out   (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= cbsp_pkg::STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            // The parse state moves only when a byte is actually consumed.
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
